@@ rtl/mcm_pkg.sv @@
// Shared types, constants and lookup functions for the mesh cell measure block.
package mcm_pkg;

    localparam int COORD_BITS    = 16;
    localparam int MAX_NODES_DEF = 16;
    localparam int MEAS_W        = 48;
    localparam int STAT_W        = 3;
    localparam int ACC_W         = 64;
    localparam int SQ_W          = 128;

    // result status codes
    localparam logic [STAT_W-1:0] STATUS_OK        = 3'd0;
    localparam logic [STAT_W-1:0] STATUS_UNMEAS    = 3'd1;
    localparam logic [STAT_W-1:0] STATUS_FEW_COMP  = 3'd2;
    localparam logic [STAT_W-1:0] STATUS_FEW_NODES = 3'd3;
    localparam logic [STAT_W-1:0] STATUS_TOO_MANY  = 3'd4;

    // cell type codes
    localparam logic [7:0] KIND_LINE    = 8'd3;
    localparam logic [7:0] KIND_TRI     = 8'd5;
    localparam logic [7:0] KIND_POLY    = 8'd7;
    localparam logic [7:0] KIND_QUAD    = 8'd9;
    localparam logic [7:0] KIND_TET     = 8'd10;
    localparam logic [7:0] KIND_HEX     = 8'd12;
    localparam logic [7:0] KIND_WEDGE   = 8'd13;
    localparam logic [7:0] KIND_PYRAMID = 8'd14;

    // product steps of the arithmetic sequencer
    localparam logic [3:0] K_CROSS_FIRST = 4'd0;
    localparam logic [3:0] K_CROSS_END   = 4'd5;
    localparam logic [3:0] K_DOT_FIRST   = 4'd6;
    localparam logic [3:0] K_DOT_END     = 4'd8;
    localparam logic [3:0] K_SUMSQ_FIRST = 4'd9;
    localparam logic [3:0] K_SUMSQ_END   = 4'd11;
    localparam logic [3:0] K_DIV         = 4'd12;

    // volume divisor is 6 * 2^8: shift by 9, then divide by 3 through a
    // reciprocal multiply (high bits from 65 up give the exact quotient)
    localparam int VOL_SHIFT = 9;
    localparam logic [ACC_W-1:0] RECIP_THREE = 64'hAAAA_AAAA_AAAA_AAAB;
    localparam int RECIP_SHIFT = 65;

    typedef struct packed {
        logic signed [COORD_BITS-1:0] x_coord;
        logic signed [COORD_BITS-1:0] y_coord;
        logic signed [COORD_BITS-1:0] z_coord;
        logic [7:0]                   cell_kind;
        logic                         last_node;
    } mcm_in_t;

    typedef struct packed {
        logic [MEAS_W-1:0] measure;
        logic [STAT_W-1:0] status;
    } mcm_out_t;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_FETCH,
        ST_LOAD,
        ST_MUL,
        ST_MWAIT,
        ST_SQRT,
        ST_SWAIT,
        ST_DONE
    } mcm_state_t;

    typedef enum logic [1:0] {
        MODE_LINE,
        MODE_AREA,
        MODE_TET
    } mcm_mode_t;

    // tetra sets: hex 0..5, wedge 6..8, pyramid 9..10, tet 11
    localparam logic [2:0] TET_SETS [12][4] = '{
        '{3'd0, 3'd1, 3'd2, 3'd6}, '{3'd0, 3'd2, 3'd3, 3'd6}, '{3'd0, 3'd3, 3'd7, 3'd6},
        '{3'd0, 3'd7, 3'd4, 3'd6}, '{3'd0, 3'd4, 3'd5, 3'd6}, '{3'd0, 3'd5, 3'd1, 3'd6},
        '{3'd0, 3'd1, 3'd2, 3'd3}, '{3'd1, 3'd2, 3'd3, 3'd4}, '{3'd2, 3'd3, 3'd4, 3'd5},
        '{3'd0, 3'd1, 3'd2, 3'd4}, '{3'd0, 3'd2, 3'd3, 3'd4},
        '{3'd0, 3'd1, 3'd2, 3'd3}
    };

    function automatic logic [2:0] tet_node(logic [3:0] idx, logic [1:0] f);
        return TET_SETS[idx][f];
    endfunction

    function automatic logic [1:0] kind_dim(logic [7:0] kind);
        case (kind)
            KIND_LINE:                                   return 2'd1;
            KIND_TRI, KIND_POLY, KIND_QUAD:              return 2'd2;
            KIND_TET, KIND_HEX, KIND_WEDGE, KIND_PYRAMID: return 2'd3;
            default:                                     return 2'd0;
        endcase
    endfunction

    function automatic logic [3:0] kind_need(logic [7:0] kind);
        case (kind)
            KIND_LINE:           return 4'd2;
            KIND_TRI, KIND_POLY: return 4'd3;
            KIND_QUAD, KIND_TET: return 4'd4;
            KIND_PYRAMID:        return 4'd5;
            KIND_WEDGE:          return 4'd6;
            KIND_HEX:            return 4'd8;
            default:             return 4'd0;
        endcase
    endfunction

    function automatic mcm_mode_t kind_mode(logic [7:0] kind);
        case (kind)
            KIND_LINE:                      return MODE_LINE;
            KIND_TRI, KIND_POLY, KIND_QUAD: return MODE_AREA;
            default:                        return MODE_TET;
        endcase
    endfunction

    // first and last tetra of a volume cell
    function automatic logic [3:0] tet_first(logic [7:0] kind);
        case (kind)
            KIND_HEX:     return 4'd0;
            KIND_WEDGE:   return 4'd6;
            KIND_PYRAMID: return 4'd9;
            default:      return 4'd11;
        endcase
    endfunction

    function automatic logic [3:0] tet_final(logic [7:0] kind);
        case (kind)
            KIND_HEX:     return 4'd5;
            KIND_WEDGE:   return 4'd8;
            KIND_PYRAMID: return 4'd10;
            default:      return 4'd11;
        endcase
    endfunction

endpackage

@@ rtl/mcm_ram.sv @@
// Generic single-port-write, single-port-read RAM with registered read data.
module mcm_ram #(
    parameter int WIDTH = 48,
    parameter int DEPTH = 16
) (
    input  logic                     aclk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    // write port and registered read port
    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

@@ rtl/mcm_mul.sv @@
// Iterative 64x64 to 128-bit multiplier built from one 32x32 multiplier.
module mcm_mul (
    input  logic         aclk,
    input  logic         aresetn,
    input  logic         start,
    input  logic [63:0]  a,
    input  logic [63:0]  b,
    output logic         done,
    output logic [127:0] prod
);

    logic         run_reg;
    logic [2:0]   cnt_reg;
    logic         done_reg;
    logic [63:0]  a_reg;
    logic [63:0]  b_reg;
    logic [63:0]  pp_reg;
    logic [1:0]   sh_reg;
    logic [127:0] acc_reg;
    logic [31:0]  a_part;
    logic [31:0]  b_part;
    logic [63:0]  pp_next;
    logic [127:0] addend;

    // pick the halves for this partial product
    always_comb begin
        case (cnt_reg[1:0])
            2'd0:    begin a_part = a_reg[31:0];  b_part = b_reg[31:0];  end
            2'd1:    begin a_part = a_reg[31:0];  b_part = b_reg[63:32]; end
            2'd2:    begin a_part = a_reg[63:32]; b_part = b_reg[31:0];  end
            default: begin a_part = a_reg[63:32]; b_part = b_reg[63:32]; end
        endcase
    end

    assign pp_next = a_part * b_part;

    // align the registered partial product
    always_comb begin
        case (sh_reg)
            2'd0:    addend = {64'd0, pp_reg};
            2'd1,
            2'd2:    addend = {32'd0, pp_reg, 32'd0};
            default: addend = {pp_reg, 64'd0};
        endcase
    end

    // control
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            run_reg  <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= 3'd0;
        end else begin
            done_reg <= 1'b0;
            if (start) begin
                run_reg <= 1'b1;
                cnt_reg <= 3'd0;
            end else if (run_reg) begin
                cnt_reg <= cnt_reg + 3'd1;
                if (cnt_reg == 3'd4) begin
                    run_reg  <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    // datapath: partial product registered, accumulated in the next cycle
    always_ff @(posedge aclk) begin
        if (start) begin
            a_reg   <= a;
            b_reg   <= b;
            acc_reg <= '0;
        end else if (run_reg) begin
            pp_reg <= pp_next;
            sh_reg <= cnt_reg[1:0];
            if (cnt_reg != 3'd0) begin
                acc_reg <= acc_reg + addend;
            end
        end
    end

    assign done = done_reg;
    assign prod = acc_reg;

endmodule

@@ rtl/mcm_sqrt.sv @@
// Digit-by-digit integer square root of a 128-bit value, one root bit per cycle.
module mcm_sqrt (
    input  logic         aclk,
    input  logic         aresetn,
    input  logic         start,
    input  logic [127:0] radicand,
    output logic         done,
    output logic [63:0]  root
);

    logic         run_reg;
    logic         done_reg;
    logic [5:0]   cnt_reg;
    logic [127:0] rad_reg;
    logic [65:0]  rem_reg;
    logic [63:0]  root_reg;
    logic [67:0]  rem_sh;
    logic [67:0]  trial;
    logic         fits;

    assign rem_sh = {rem_reg, rad_reg[127:126]};
    assign trial  = {2'b00, root_reg, 2'b01};
    assign fits   = rem_sh >= trial;

    // control
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            run_reg  <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= 6'd0;
        end else begin
            done_reg <= 1'b0;
            if (start) begin
                run_reg <= 1'b1;
                cnt_reg <= 6'd0;
            end else if (run_reg) begin
                cnt_reg <= cnt_reg + 6'd1;
                if (cnt_reg == 6'd63) begin
                    run_reg  <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    // bring down two bits, try the next root bit
    always_ff @(posedge aclk) begin
        if (start) begin
            rad_reg  <= radicand;
            rem_reg  <= '0;
            root_reg <= '0;
        end else if (run_reg) begin
            rad_reg <= {rad_reg[125:0], 2'b00};
            if (fits) begin
                rem_reg  <= 66'(rem_sh - trial);
                root_reg <= {root_reg[62:0], 1'b1};
            end else begin
                rem_reg  <= rem_sh[65:0];
                root_reg <= {root_reg[62:0], 1'b0};
            end
        end
    end

    assign done = done_reg;
    assign root = root_reg;

endmodule

@@ rtl/mesh_cell_measure.sv @@
// Top level: node store, product sequencer and result register of the cell measure block.
// Nodes that are not last are taken one per cycle while idle. After a last node the cell is
// measured as a line, area or volume; a cell with an error status skips the products.
// Each product runs on one shared 32x32 multiplier (4 partials), the root on its own unit;
// the volume divide by 3 is one reciprocal product. The next cell is taken after the result.
// Reset (aresetn low, synchronous) empties the cell, sets the component count to 3.
module mesh_cell_measure #(
    parameter int MAX_NODES = mcm_pkg::MAX_NODES_DEF
) (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              s_valid,
    output logic              s_ready,
    input  mcm_pkg::mcm_in_t  s_data,
    output logic              m_valid,
    input  logic              m_ready,
    output mcm_pkg::mcm_out_t m_data,
    input  logic              cfg_valid,
    output logic              cfg_ready,
    input  logic [1:0]        cfg_data
);

    import mcm_pkg::*;

    localparam int AW = $clog2(MAX_NODES);
    localparam int CW = $clog2(MAX_NODES + 1);
    localparam int RW = 3 * COORD_BITS;

    mcm_state_t state_reg, state_next;
    mcm_mode_t  mode_reg;

    logic [1:0]          comps_reg;
    logic [1:0]          act_reg;
    logic [CW-1:0]       cnt_reg;
    logic                ovf_reg;
    logic [STAT_W-1:0]   status_reg;
    logic [1:0]          f_reg;
    logic [3:0]          k_reg;
    logic [AW-1:0]       edge_reg;
    logic [CW-1:0]       ncnt_reg;
    logic [3:0]          tet_reg;
    logic [3:0]          tet_last_reg;
    logic [ACC_W-1:0]    base_reg [3];
    logic [ACC_W-1:0]    u_reg    [3];
    logic [ACC_W-1:0]    va_reg   [3];
    logic [ACC_W-1:0]    vb_reg   [3];
    logic [ACC_W-1:0]    c_reg    [3];
    logic [ACC_W-1:0]    t_reg;
    logic [SQ_W-1:0]     s_reg;
    logic [ACC_W-1:0]    dv_reg;
    logic [ACC_W-1:0]    meas_reg;
    logic                m_valid_reg;
    mcm_out_t            m_data_reg;

    logic                in_acc;
    logic                has_room;
    logic [CW-1:0]       cnt_new;
    logic                ovf_new;
    logic [1:0]          dim;
    logic [STAT_W-1:0]   stat_calc;
    logic [AW-1:0]       edge_j;
    logic                edge_last;
    logic                tet_end;
    logic                load_last;
    logic [AW-1:0]       raddr;
    logic [RW-1:0]       rdata;
    logic [ACC_W-1:0]    lc [3];
    logic [ACC_W-1:0]    op_a;
    logic [ACC_W-1:0]    op_b;
    logic                mul_start;
    logic                mul_done;
    logic [SQ_W-1:0]     mul_prod;
    logic                sq_start;
    logic                sq_done;
    logic [63:0]         sq_root;
    logic [SQ_W-1:0]     sq_in;
    logic [ACC_W-1:0]    t_mag;
    logic                out_free;

    function automatic logic [ACC_W-1:0] mag(logic [ACC_W-1:0] v);
        return v[ACC_W-1] ? ACC_W'(-v) : v;
    endfunction

    function automatic logic [ACC_W-1:0] coord_ext(logic [COORD_BITS-1:0] v);
        return ACC_W'(signed'(v));
    endfunction

    // node bookkeeping and status of a finished cell
    assign in_acc    = s_valid && s_ready;
    assign has_room  = cnt_reg < CW'(MAX_NODES);
    assign cnt_new   = has_room ? CW'(cnt_reg + 1'b1) : cnt_reg;
    assign ovf_new   = ovf_reg || !has_room;
    assign dim       = kind_dim(s_data.cell_kind);

    always_comb begin
        if (dim == 2'd0) begin
            stat_calc = STATUS_UNMEAS;
        end else if (comps_reg < dim) begin
            stat_calc = STATUS_FEW_COMP;
        end else if (ovf_new) begin
            stat_calc = STATUS_TOO_MANY;
        end else if (cnt_new < CW'(kind_need(s_data.cell_kind))) begin
            stat_calc = STATUS_FEW_NODES;
        end else begin
            stat_calc = STATUS_OK;
        end
    end

    // node walk
    assign edge_last = CW'(edge_reg) == CW'(ncnt_reg - 1'b1);
    assign edge_j    = edge_last ? '0 : AW'(edge_reg + 1'b1);
    assign tet_end   = tet_reg == tet_last_reg;
    assign load_last = (mode_reg == MODE_TET) ? (f_reg == 2'd3) : (f_reg == 2'd1);

    always_comb begin
        case (mode_reg)
            MODE_LINE: raddr = AW'(f_reg);
            MODE_AREA: raddr = (f_reg == 2'd0) ? edge_reg : edge_j;
            default:   raddr = AW'(tet_node(tet_reg, f_reg));
        endcase
    end

    mcm_ram #(
        .WIDTH (RW),
        .DEPTH (MAX_NODES)
    ) u_store (
        .aclk  (aclk),
        .we    (in_acc && has_room),
        .waddr (cnt_reg[AW-1:0]),
        .wdata ({s_data.z_coord, s_data.y_coord, s_data.x_coord}),
        .raddr (raddr),
        .rdata (rdata)
    );

    // unpack the read node, dropping components that are not in use
    always_comb begin
        for (int i = 0; i < 3; i++) begin
            lc[i] = (2'(i) < act_reg) ? coord_ext(rdata[i*COORD_BITS +: COORD_BITS]) : '0;
        end
    end

    // operand select for each product step
    always_comb begin
        op_a = '0;
        op_b = '0;
        case (k_reg)
            4'd0:  begin op_a = va_reg[1]; op_b = vb_reg[2]; end
            4'd1:  begin op_a = va_reg[2]; op_b = vb_reg[1]; end
            4'd2:  begin op_a = va_reg[2]; op_b = vb_reg[0]; end
            4'd3:  begin op_a = va_reg[0]; op_b = vb_reg[2]; end
            4'd4:  begin op_a = va_reg[0]; op_b = vb_reg[1]; end
            4'd5:  begin op_a = va_reg[1]; op_b = vb_reg[0]; end
            4'd6:  begin op_a = u_reg[0];  op_b = c_reg[0];  end
            4'd7:  begin op_a = u_reg[1];  op_b = c_reg[1];  end
            4'd8:  begin op_a = u_reg[2];  op_b = c_reg[2];  end
            4'd9:  begin op_a = mag(c_reg[0]); op_b = mag(c_reg[0]); end
            4'd10: begin op_a = mag(c_reg[1]); op_b = mag(c_reg[1]); end
            4'd11: begin op_a = mag(c_reg[2]); op_b = mag(c_reg[2]); end
            K_DIV: begin op_a = dv_reg; op_b = RECIP_THREE; end
            default: begin op_a = '0; op_b = '0; end
        endcase
    end

    assign mul_start = state_reg == ST_MUL;

    mcm_mul u_mul (
        .aclk    (aclk),
        .aresetn (aresetn),
        .start   (mul_start),
        .a       (op_a),
        .b       (op_b),
        .done    (mul_done),
        .prod    (mul_prod)
    );

    assign sq_start = state_reg == ST_SQRT;
    assign sq_in    = (mode_reg == MODE_LINE) ? {s_reg[SQ_W-17:0], 16'd0} : s_reg;

    mcm_sqrt u_sqrt (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .start    (sq_start),
        .radicand (sq_in),
        .done     (sq_done),
        .root     (sq_root)
    );

    // magnitude of the volume sum with the last dot product added in
    assign t_mag   = mag(ACC_W'(t_reg + mul_prod[ACC_W-1:0]));

    assign out_free  = !m_valid_reg || m_ready;
    assign s_ready   = state_reg == ST_IDLE;
    assign cfg_ready = 1'b1;

    // next state
    always_comb begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE: begin
                if (in_acc && s_data.last_node) begin
                    state_next = (stat_calc == STATUS_OK) ? ST_FETCH : ST_DONE;
                end
            end
            ST_FETCH: state_next = ST_LOAD;
            ST_LOAD:  state_next = load_last ? ST_MUL : ST_FETCH;
            ST_MUL:   state_next = ST_MWAIT;
            ST_MWAIT: begin
                if (mul_done) begin
                    if (k_reg == K_CROSS_END) begin
                        state_next = (mode_reg == MODE_AREA && !edge_last) ? ST_FETCH : ST_MUL;
                    end else if (k_reg == K_DOT_END) begin
                        state_next = tet_end ? ST_MUL : ST_FETCH;
                    end else if (k_reg == K_SUMSQ_END) begin
                        state_next = ST_SQRT;
                    end else if (k_reg == K_DIV) begin
                        state_next = ST_DONE;
                    end else begin
                        state_next = ST_MUL;
                    end
                end
            end
            ST_SQRT:  state_next = ST_SWAIT;
            ST_SWAIT: state_next = sq_done ? ST_DONE : ST_SWAIT;
            ST_DONE:  state_next = out_free ? ST_IDLE : ST_DONE;
            default:  state_next = ST_IDLE;
        endcase
    end

    // control registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            comps_reg   <= 2'd3;
            cnt_reg     <= '0;
            ovf_reg     <= 1'b0;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg <= state_next;
            if (cfg_valid && cfg_ready) begin
                comps_reg <= cfg_data;
            end
            if (in_acc) begin
                cnt_reg <= s_data.last_node ? '0 : cnt_new;
                ovf_reg <= s_data.last_node ? 1'b0 : ovf_new;
            end
            if (state_reg == ST_DONE && out_free) begin
                m_valid_reg <= 1'b1;
            end else if (m_ready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    // datapath registers
    always_ff @(posedge aclk) begin
        case (state_reg)
            ST_IDLE: begin
                if (in_acc && s_data.last_node) begin
                    status_reg   <= stat_calc;
                    meas_reg     <= '0;
                    act_reg      <= comps_reg;
                    mode_reg     <= kind_mode(s_data.cell_kind);
                    f_reg        <= 2'd0;
                    k_reg        <= K_CROSS_FIRST;
                    edge_reg     <= '0;
                    ncnt_reg     <= cnt_new;
                    tet_reg      <= tet_first(s_data.cell_kind);
                    tet_last_reg <= tet_final(s_data.cell_kind);
                    t_reg        <= '0;
                    s_reg        <= '0;
                    for (int i = 0; i < 3; i++) begin
                        c_reg[i] <= '0;
                    end
                end
            end
            ST_LOAD: begin
                for (int i = 0; i < 3; i++) begin
                    case (mode_reg)
                        MODE_LINE: begin
                            if (f_reg == 2'd0) base_reg[i] <= lc[i];
                            else               c_reg[i]    <= lc[i] - base_reg[i];
                        end
                        MODE_AREA: begin
                            if (f_reg == 2'd0) va_reg[i] <= lc[i];
                            else               vb_reg[i] <= lc[i];
                        end
                        default: begin
                            case (f_reg)
                                2'd0:    base_reg[i] <= lc[i];
                                2'd1:    u_reg[i]    <= lc[i] - base_reg[i];
                                2'd2:    va_reg[i]   <= lc[i] - base_reg[i];
                                default: vb_reg[i]   <= lc[i] - base_reg[i];
                            endcase
                        end
                    endcase
                end
                if (load_last) begin
                    k_reg <= (mode_reg == MODE_LINE) ? K_SUMSQ_FIRST : K_CROSS_FIRST;
                end else begin
                    f_reg <= f_reg + 2'd1;
                end
            end
            ST_MWAIT: begin
                if (mul_done) begin
                    // accumulate the product
                    case (k_reg)
                        4'd0:    c_reg[0] <= c_reg[0] + mul_prod[ACC_W-1:0];
                        4'd1:    c_reg[0] <= c_reg[0] - mul_prod[ACC_W-1:0];
                        4'd2:    c_reg[1] <= c_reg[1] + mul_prod[ACC_W-1:0];
                        4'd3:    c_reg[1] <= c_reg[1] - mul_prod[ACC_W-1:0];
                        4'd4:    c_reg[2] <= c_reg[2] + mul_prod[ACC_W-1:0];
                        4'd5:    c_reg[2] <= c_reg[2] - mul_prod[ACC_W-1:0];
                        4'd6,
                        4'd7:    t_reg    <= t_reg + mul_prod[ACC_W-1:0];
                        4'd8: begin
                            t_reg <= t_reg + mul_prod[ACC_W-1:0];
                            for (int i = 0; i < 3; i++) begin
                                c_reg[i] <= '0;
                            end
                        end
                        K_DIV:   meas_reg <= ACC_W'(mul_prod[SQ_W-1:RECIP_SHIFT]);
                        default: s_reg <= s_reg + mul_prod;
                    endcase
                    // advance the step
                    if (k_reg == K_CROSS_END) begin
                        if (mode_reg == MODE_TET) begin
                            k_reg <= K_DOT_FIRST;
                        end else if (edge_last) begin
                            k_reg <= K_SUMSQ_FIRST;
                        end else begin
                            edge_reg <= AW'(edge_reg + 1'b1);
                            f_reg    <= 2'd0;
                            k_reg    <= K_CROSS_FIRST;
                        end
                    end else if (k_reg == K_DOT_END) begin
                        if (tet_end) begin
                            dv_reg <= t_mag >> VOL_SHIFT;
                            k_reg  <= K_DIV;
                        end else begin
                            tet_reg <= tet_reg + 4'd1;
                            f_reg   <= 2'd0;
                            k_reg   <= K_CROSS_FIRST;
                        end
                    end else if (k_reg != K_SUMSQ_END && k_reg != K_DIV) begin
                        k_reg <= k_reg + 4'd1;
                    end
                end
            end
            ST_SWAIT: begin
                if (sq_done) begin
                    meas_reg <= (mode_reg == MODE_LINE) ? sq_root : (sq_root >> 1);
                end
            end
            default: begin
            end
        endcase
    end

    // result register, saturating the measure
    always_ff @(posedge aclk) begin
        if (state_reg == ST_DONE && out_free) begin
            m_data_reg.status  <= status_reg;
            m_data_reg.measure <= (|meas_reg[ACC_W-1:MEAS_W]) ? '1 : meas_reg[MEAS_W-1:0];
        end
    end

    assign m_valid = m_valid_reg;
    assign m_data  = m_data_reg;

endmodule

@@ rtl/mcm_check.sv @@
// Port-level checks for the cell measure block, bound to its top level.
module mcm_check (
    input logic              aclk,
    input logic              aresetn,
    input logic              s_valid,
    input logic              s_ready,
    input mcm_pkg::mcm_in_t  s_data,
    input logic              m_valid,
    input logic              m_ready,
    input mcm_pkg::mcm_out_t m_data,
    input logic              cfg_valid,
    input logic              cfg_ready,
    input logic [1:0]        cfg_data
);

    import mcm_pkg::*;

    // hold a stalled result
    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_data))
        else $error("result changed while stalled");

    // drop the measure on any error
    a_err_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_data.status != STATUS_OK |-> m_data.measure == '0)
        else $error("measure not zero on error status");

    // status stays within its codes
    a_status_range: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> m_data.status <= STATUS_TOO_MANY)
        else $error("status code out of range");

    // no result right after reset
    a_reset_idle: assert property (@(posedge aclk)
        !aresetn |=> !m_valid)
        else $error("result valid after reset");

endmodule

bind mesh_cell_measure mcm_check u_check (.*);
